[src/assert_macros.svh]
// Assertion macros used by the moving-average lookup datapath.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Checked property, held off while reset is low.
`define SWA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked property that also runs through reset.
`define SWA_ASSERT_NR(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SWA_ASSERT(label, prop, msg)
`define SWA_ASSERT_NR(label, prop, msg)
`endif
`endif

[src/swa_pkg.sv]
// Shared widths, record type and controller/datapath interface structs.
package swa_pkg;

  localparam int MAX_WINDOW = 16;
  localparam int SLOT_W     = 4;
  localparam int CNT_W      = 5;
  localparam int WIN_W      = 5;
  localparam int KEY_W      = 27;
  localparam int PRICE_W    = 32;
  localparam int VOL_W      = 40;
  localparam int SUM_W      = 36;
  localparam int DIV_STEPS  = SUM_W;
  localparam int STEP_W     = $clog2(DIV_STEPS + 1);

  localparam logic [WIN_W-1:0] WINDOW_RESET = 5'd5;

  localparam logic OP_ADD    = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  typedef struct packed {
    logic [KEY_W-1:0]   date_key;
    logic [PRICE_W-1:0] open_price;
    logic [PRICE_W-1:0] high_price;
    logic [PRICE_W-1:0] low_price;
    logic [PRICE_W-1:0] close_price;
    logic [VOL_W-1:0]   volume;
  } rec_t;

  typedef struct packed {
    logic capture;
    logic evict_rd;
    logic evict_sub;
    logic write;
    logic scan_start;
    logic scan_step;
    logic div_start;
    logic load_out;
  } swa_cmd_t;

  typedef struct packed {
    logic full;
    logic scan_done;
    logic div_busy;
    logic out_stall;
  } swa_stat_t;

endpackage

[src/swa_div.sv]
// Restoring divider, one quotient bit per cycle: running close sum by entry count.
module swa_div import swa_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [SUM_W-1:0]   dividend,
  input  logic [CNT_W-1:0]   divisor,
  output logic               busy,
  output logic [PRICE_W-1:0] quotient
);

  logic [STEP_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0]  rem_r, rem_nxt;
  logic [SUM_W-1:0]  quo_r, quo_nxt;
  logic [CNT_W-1:0]  div_r, div_nxt;
  logic [CNT_W:0]    trial;
  logic              ge;

  assign trial = {rem_r, quo_r[SUM_W-1]};
  assign ge    = trial >= {1'b0, div_r};

  always_comb begin
    cnt_nxt = cnt_r;
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    div_nxt = div_r;
    if (start) begin
      cnt_nxt = STEP_W'(DIV_STEPS);
      rem_nxt = '0;
      quo_nxt = dividend;
      div_nxt = divisor;
    end else if (cnt_r != '0) begin
      cnt_nxt = cnt_r - STEP_W'(1);
      // remainder stays below the divisor, so it fits back in CNT_W bits
      rem_nxt = ge ? CNT_W'(trial - {1'b0, div_r}) : trial[CNT_W-1:0];
      quo_nxt = {quo_r[SUM_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    div_r <= div_nxt;
  end

  assign busy     = cnt_r != '0;
  assign quotient = quo_r[PRICE_W-1:0];

endmodule

[src/swa_ctrl.sv]
// Sequencer: add with eviction, newest-first lookup scan, divide, result hand-off.
module swa_ctrl import swa_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_operation,
  output logic      in_ready,
  input  swa_stat_t stat,
  output swa_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_ADD_CHK,
    S_EVICT_RD,
    S_EVICT_SUB,
    S_WRITE,
    S_DIV_GO,
    S_SCAN_GO,
    S_SCAN,
    S_WAIT
  } state_t;

  state_t state_r, state_nxt;
  logic   in_ready_r, in_ready_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready_r) begin
          cmd.capture = 1'b1;
          state_nxt   = (in_operation == OP_ADD) ? S_ADD_CHK : S_SCAN_GO;
        end
      end
      S_ADD_CHK: begin
        state_nxt = stat.full ? S_EVICT_RD : S_WRITE;
      end
      S_EVICT_RD: begin
        cmd.evict_rd = 1'b1;
        state_nxt    = S_EVICT_SUB;
      end
      S_EVICT_SUB: begin
        cmd.evict_sub = 1'b1;
        state_nxt     = S_ADD_CHK;
      end
      S_WRITE: begin
        cmd.write = 1'b1;
        state_nxt = S_DIV_GO;
      end
      S_DIV_GO: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_WAIT;
      end
      S_SCAN_GO: begin
        // sum and count do not move on a lookup, so divide alongside the scan
        cmd.scan_start = 1'b1;
        cmd.div_start  = 1'b1;
        state_nxt      = S_SCAN;
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_done) begin
          state_nxt = S_WAIT;
        end
      end
      S_WAIT: begin
        if (!stat.div_busy && !stat.out_stall) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    in_ready_nxt = state_nxt == S_IDLE;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      in_ready_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      in_ready_r <= in_ready_nxt;
    end
  end

  assign in_ready = in_ready_r;

endmodule

[src/swa_dp.sv]
// Datapath: record ring, window bookkeeping, lookup scan, divider and result register.
`include "assert_macros.svh"
module swa_dp import swa_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [WIN_W-1:0]   cfg_window_size,
  input  logic [KEY_W-1:0]   in_date_key,
  input  logic [PRICE_W-1:0] in_open_price,
  input  logic [PRICE_W-1:0] in_high_price,
  input  logic [PRICE_W-1:0] in_low_price,
  input  logic [PRICE_W-1:0] in_close_price,
  input  logic [VOL_W-1:0]   in_volume,
  input  swa_cmd_t           cmd,
  output swa_stat_t          stat,
  input  logic               out_ready,
  output logic               out_valid,
  output logic [PRICE_W-1:0] out_average_close,
  output logic [CNT_W-1:0]   out_entries_held,
  output logic               out_found,
  output logic [PRICE_W-1:0] out_found_open,
  output logic [PRICE_W-1:0] out_found_high,
  output logic [PRICE_W-1:0] out_found_low,
  output logic [PRICE_W-1:0] out_found_close,
  output logic [VOL_W-1:0]   out_found_volume
);

  rec_t mem [MAX_WINDOW];
  rec_t rec_r;
  rec_t rd_data_r;
  rec_t hit_rec_r;

  logic [WIN_W-1:0]  win_r, win_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [SLOT_W-1:0] oldest_r, oldest_nxt;
  logic [SUM_W-1:0]  sum_r, sum_nxt;
  logic [CNT_W-1:0]  idx_r, idx_nxt;
  logic              rd_pend_r, rd_pend_nxt;
  logic              found_r, found_nxt;
  logic              out_valid_r, out_valid_nxt;

  logic [PRICE_W-1:0] avg_r;
  logic [CNT_W-1:0]   held_r;
  logic               ofound_r;
  rec_t               orec_r;

  logic [WIN_W-1:0]   eff_win;
  logic [SLOT_W-1:0]  wr_addr, scan_addr, rd_addr;
  logic               scan_issue, hit, cfg_wr;
  logic               div_busy;
  logic [PRICE_W-1:0] div_q;

  assign cfg_wr = cfg_valid && cfg_ready;

  always_comb begin
    if (win_r == '0) begin
      eff_win = WIN_W'(1);
    end else if (win_r > WIN_W'(MAX_WINDOW)) begin
      eff_win = WIN_W'(MAX_WINDOW);
    end else begin
      eff_win = win_r;
    end
  end

  assign wr_addr   = oldest_r + count_r[SLOT_W-1:0];
  // idx counts down from the newest held entry; index 0 of a full ring wraps
  assign scan_addr = oldest_r + idx_r[SLOT_W-1:0] - SLOT_W'(1);
  assign rd_addr   = cmd.evict_rd ? oldest_r : scan_addr;

  assign scan_issue = cmd.scan_step && (idx_r != '0) && !found_r;
  assign hit        = cmd.scan_step && rd_pend_r && !found_r &&
                      (rd_data_r.date_key == rec_r.date_key);

  always_comb begin
    win_nxt       = win_r;
    count_nxt     = count_r;
    oldest_nxt    = oldest_r;
    sum_nxt       = sum_r;
    idx_nxt       = idx_r;
    rd_pend_nxt   = rd_pend_r;
    found_nxt     = found_r;
    out_valid_nxt = out_valid_r;

    if (cfg_wr) begin
      win_nxt    = cfg_window_size;
      count_nxt  = '0;
      oldest_nxt = '0;
      sum_nxt    = '0;
    end else if (cmd.evict_sub) begin
      count_nxt  = count_r - CNT_W'(1);
      oldest_nxt = oldest_r + SLOT_W'(1);
      sum_nxt    = sum_r - SUM_W'(rd_data_r.close_price);
    end else if (cmd.write) begin
      count_nxt = count_r + CNT_W'(1);
      sum_nxt   = sum_r + SUM_W'(rec_r.close_price);
    end

    if (cmd.capture) begin
      found_nxt = 1'b0;
    end else if (hit) begin
      found_nxt = 1'b1;
    end

    if (cmd.scan_start) begin
      idx_nxt     = count_r;
      rd_pend_nxt = 1'b0;
    end else if (cmd.scan_step) begin
      rd_pend_nxt = scan_issue;
      if (scan_issue) begin
        idx_nxt = idx_r - CNT_W'(1);
      end
    end

    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r       <= WINDOW_RESET;
      count_r     <= '0;
      oldest_r    <= '0;
      sum_r       <= '0;
      idx_r       <= '0;
      rd_pend_r   <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      win_r       <= win_nxt;
      count_r     <= count_nxt;
      oldest_r    <= oldest_nxt;
      sum_r       <= sum_nxt;
      idx_r       <= idx_nxt;
      rd_pend_r   <= rd_pend_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // record ring
  always_ff @(posedge clk) begin
    if (cmd.write) begin
      mem[wr_addr] <= rec_r;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      rec_r.date_key    <= in_date_key;
      rec_r.open_price  <= in_open_price;
      rec_r.high_price  <= in_high_price;
      rec_r.low_price   <= in_low_price;
      rec_r.close_price <= in_close_price;
      rec_r.volume      <= in_volume;
    end
    if (hit) begin
      hit_rec_r <= rd_data_r;
    end
    if (cmd.load_out) begin
      avg_r    <= (count_r == '0) ? '0 : div_q;
      held_r   <= count_r;
      ofound_r <= found_r;
      orec_r   <= found_r ? hit_rec_r : '0;
    end
  end

  swa_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (sum_r),
    .divisor  (count_r),
    .busy     (div_busy),
    .quotient (div_q)
  );

  assign stat.full      = count_r >= eff_win;
  assign stat.scan_done = found_r || ((idx_r == '0) && !rd_pend_r);
  assign stat.div_busy  = div_busy;
  assign stat.out_stall = out_valid_r && !out_ready;

  assign out_valid         = out_valid_r;
  assign out_average_close = avg_r;
  assign out_entries_held  = held_r;
  assign out_found         = ofound_r;
  assign out_found_open    = orec_r.open_price;
  assign out_found_high    = orec_r.high_price;
  assign out_found_low     = orec_r.low_price;
  assign out_found_close   = orec_r.close_price;
  assign out_found_volume  = orec_r.volume;

  `SWA_ASSERT(a_count_in_window, count_r <= eff_win, "entry count exceeds window")
  `SWA_ASSERT(a_empty_sum_zero, (count_r == '0) |-> (sum_r == '0), "empty window, nonzero sum")
  `SWA_ASSERT(a_load_after_div, cmd.load_out |-> !div_busy, "result loaded mid-divide")
  `SWA_ASSERT_NR(a_reset_clears, !rst_n |=> (count_r == '0) && !out_valid_r, "reset left state")

endmodule

[src/sliding_window_average_keyed_lookup.sv]
// Top level: moving average of close prices with date-keyed record lookup.
//
// Input channel (in_valid/in_ready): one item per handshake. Operation add
// appends a price record, evicting the oldest one when the window is full;
// operation lookup finds the newest held record with a matching date key.
// Result channel (out_valid/out_ready): one item per input item, carrying the
// truncated average close, the entry count and, for a lookup hit, the record.
// Config channel (cfg_valid/cfg_ready, always ready): writes window_size and
// empties the window. Write it only while no item is in flight.
// The 36-step bit-serial divider is the longest step from accept to out_valid;
// the lookup scan (one entry a cycle, newest first) runs beside it.
// One item is worked at a time; the next is taken the cycle after its result
// is registered. A result waiting on out_ready holds the block in its last
// step until taken. Reset (rst_n low, synchronous) empties the window, sets
// window_size to 5 and drops any pending result.
module sliding_window_average_keyed_lookup import swa_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [WIN_W-1:0]   cfg_window_size,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_operation,
  input  logic [KEY_W-1:0]   in_date_key,
  input  logic [PRICE_W-1:0] in_open_price,
  input  logic [PRICE_W-1:0] in_high_price,
  input  logic [PRICE_W-1:0] in_low_price,
  input  logic [PRICE_W-1:0] in_close_price,
  input  logic [VOL_W-1:0]   in_volume,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [PRICE_W-1:0] out_average_close,
  output logic [CNT_W-1:0]   out_entries_held,
  output logic               out_found,
  output logic [PRICE_W-1:0] out_found_open,
  output logic [PRICE_W-1:0] out_found_high,
  output logic [PRICE_W-1:0] out_found_low,
  output logic [PRICE_W-1:0] out_found_close,
  output logic [VOL_W-1:0]   out_found_volume
);

  swa_cmd_t  cmd;
  swa_stat_t stat;

  assign cfg_ready = 1'b1;

  swa_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_operation (in_operation),
    .in_ready     (in_ready),
    .stat         (stat),
    .cmd          (cmd)
  );

  swa_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_window_size   (cfg_window_size),
    .in_date_key       (in_date_key),
    .in_open_price     (in_open_price),
    .in_high_price     (in_high_price),
    .in_low_price      (in_low_price),
    .in_close_price    (in_close_price),
    .in_volume         (in_volume),
    .cmd               (cmd),
    .stat              (stat),
    .out_ready         (out_ready),
    .out_valid         (out_valid),
    .out_average_close (out_average_close),
    .out_entries_held  (out_entries_held),
    .out_found         (out_found),
    .out_found_open    (out_found_open),
    .out_found_high    (out_found_high),
    .out_found_low     (out_found_low),
    .out_found_close   (out_found_close),
    .out_found_volume  (out_found_volume)
  );

endmodule

[bench/sliding_window_average_keyed_lookup_tb.sv]
// Self-checking bench for the moving-average block with date-keyed record lookup.
module sliding_window_average_keyed_lookup_tb;
  import swa_pkg::*;

  localparam int unsigned RUN_LIMIT = 1000000;
  localparam int PHASES = 8;
  localparam int ITEMS_PER_PHASE = 231;
  localparam logic [KEY_W-1:0] KEY_ALL_ONES = '1;

  typedef enum logic [1:0] {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  typedef struct packed {
    logic op;
    logic settle;   // hold this item until every earlier result is back
    rec_t rec;
  } price_item_t;

  typedef struct packed {
    logic [PRICE_W-1:0] average_close;
    logic [CNT_W-1:0]   entries_held;
    logic               found;
    logic [PRICE_W-1:0] found_open;
    logic [PRICE_W-1:0] found_high;
    logic [PRICE_W-1:0] found_low;
    logic [PRICE_W-1:0] found_close;
    logic [VOL_W-1:0]   found_volume;
  } window_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [WIN_W-1:0] cfg_window_size = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_operation = OP_ADD;
  logic [KEY_W-1:0] in_date_key = '0;
  logic [PRICE_W-1:0] in_open_price = '0;
  logic [PRICE_W-1:0] in_high_price = '0;
  logic [PRICE_W-1:0] in_low_price = '0;
  logic [PRICE_W-1:0] in_close_price = '0;
  logic [VOL_W-1:0] in_volume = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [PRICE_W-1:0] out_average_close;
  logic [CNT_W-1:0] out_entries_held;
  logic out_found;
  logic [PRICE_W-1:0] out_found_open;
  logic [PRICE_W-1:0] out_found_high;
  logic [PRICE_W-1:0] out_found_low;
  logic [PRICE_W-1:0] out_found_close;
  logic [VOL_W-1:0] out_found_volume;

  sliding_window_average_keyed_lookup u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_window_size   (cfg_window_size),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_operation      (in_operation),
    .in_date_key       (in_date_key),
    .in_open_price     (in_open_price),
    .in_high_price     (in_high_price),
    .in_low_price      (in_low_price),
    .in_close_price    (in_close_price),
    .in_volume         (in_volume),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_average_close (out_average_close),
    .out_entries_held  (out_entries_held),
    .out_found         (out_found),
    .out_found_open    (out_found_open),
    .out_found_high    (out_found_high),
    .out_found_low     (out_found_low),
    .out_found_close   (out_found_close),
    .out_found_volume  (out_found_volume)
  );

  // Predicted window contents
  rec_t ring [MAX_WINDOW];
  logic [WIN_W-1:0]  window_reg = WINDOW_RESET;
  logic [SLOT_W-1:0] oldest = '0;
  logic [CNT_W-1:0]  held = '0;
  logic [SUM_W-1:0]  close_sum = '0;

  price_item_t pending_items[$];
  window_result_t expected_results[$];
  logic [KEY_W-1:0] recent_keys[$];
  price_item_t cur_item;
  window_result_t want;
  idle_mode_t idle_mode = IDLE_NONE;
  int send_gap_pct;
  int recv_stall_pct;
  int accepted_count = 0;
  int result_count = 0;
  int total_queued = 0;
  int fail_count = 0;
  int unsigned cycle_count = 0;
  logic [WIN_W-1:0] window_plan [PHASES] =
    '{5'd16, 5'd1, 5'd0, 5'd31, 5'd7, 5'd17, 5'd16, 5'd2};

  initial begin
    forever #6 clk = ~clk;
  end

  always_comb begin
    send_gap_pct = (idle_mode == IDLE_SENDER) ? 87 : (idle_mode == IDLE_BOTH) ? 12 : 0;
    recv_stall_pct = (idle_mode == IDLE_RECEIVER) ? 87 : (idle_mode == IDLE_BOTH) ? 12 : 0;
  end

  function automatic window_result_t apply_item(input price_item_t it);
    window_result_t r;
    logic [CNT_W-1:0] win;
    logic [SLOT_W-1:0] slot;
    int i;
    r = '0;
    if (window_reg == '0) win = CNT_W'(1);
    else if (window_reg > WIN_W'(MAX_WINDOW)) win = CNT_W'(MAX_WINDOW);
    else win = window_reg;
    if (it.op == OP_ADD) begin
      while (held >= win) begin
        close_sum -= SUM_W'(ring[oldest].close_price);
        oldest++;
        held--;
      end
      slot = oldest + held[SLOT_W-1:0];
      ring[slot] = it.rec;
      close_sum += SUM_W'(it.rec.close_price);
      held++;
    end else begin
      // newest first, so a later duplicate date wins
      for (i = int'(held); i > 0 && !r.found; i--) begin
        slot = oldest + SLOT_W'(i - 1);
        if (ring[slot].date_key == it.rec.date_key) begin
          r.found        = 1'b1;
          r.found_open   = ring[slot].open_price;
          r.found_high   = ring[slot].high_price;
          r.found_low    = ring[slot].low_price;
          r.found_close  = ring[slot].close_price;
          r.found_volume = ring[slot].volume;
        end
      end
    end
    r.average_close = (held != '0) ? PRICE_W'(close_sum / held) : '0;
    r.entries_held = held;
    return r;
  endfunction

  function automatic logic [PRICE_W-1:0] random_price();
    int pick;
    pick = $urandom_range(0, 19);
    if (pick == 0) return '0;
    if (pick == 1) return '1;
    return $urandom;
  endfunction

  // Lookups mostly hit recently added dates; adds often repeat a date.
  function automatic price_item_t random_item();
    price_item_t it;
    int pick;
    it.settle = ($urandom_range(0, 59) == 0);
    it.op = ($urandom_range(0, 99) < 45) ? OP_LOOKUP : OP_ADD;
    pick = $urandom_range(0, 99);
    if (recent_keys.size() != 0 && pick < ((it.op == OP_LOOKUP) ? 65 : 30))
      it.rec.date_key = recent_keys[$urandom_range(0, recent_keys.size() - 1)];
    else if (pick < 85)
      it.rec.date_key = KEY_W'(20240101 + $urandom_range(0, 30));
    else
      it.rec.date_key = KEY_W'($urandom);
    it.rec.open_price = random_price();
    it.rec.high_price = random_price();
    it.rec.low_price = random_price();
    it.rec.close_price = random_price();
    pick = $urandom_range(0, 19);
    if (pick == 0) it.rec.volume = '0;
    else if (pick == 1) it.rec.volume = '1;
    else it.rec.volume = VOL_W'({$urandom, $urandom});
    if (it.op == OP_ADD) begin
      recent_keys.insert(recent_keys.size(), it.rec.date_key);
      if (recent_keys.size() > 24) recent_keys.delete(0);
    end
    return it;
  endfunction

  task automatic enqueue_directed(input logic op, input logic [KEY_W-1:0] key,
                                  input logic [PRICE_W-1:0] o, input logic [PRICE_W-1:0] h,
                                  input logic [PRICE_W-1:0] l, input logic [PRICE_W-1:0] c,
                                  input logic [VOL_W-1:0] v, input logic settle);
    price_item_t it;
    it.op = op;
    it.settle = settle;
    it.rec = '{date_key: key, open_price: o, high_price: h, low_price: l,
               close_price: c, volume: v};
    pending_items.insert(pending_items.size(), it);
    total_queued++;
  endtask

  task automatic wait_drained();
    while (result_count != total_queued) @(posedge clk);
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] exp_val);
    $display("mismatch at result %0d: %s got %0h expected %0h",
             result_count, what, got, exp_val);
    fail_count++;
  endtask

  // Input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_results.insert(expected_results.size(), apply_item(cur_item));
        accepted_count <= accepted_count + 1;
      end
      if (!in_valid || in_ready) begin
        if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_gap_pct &&
            !(pending_items[0].settle &&
              (accepted_count != result_count || (in_valid && in_ready)))) begin
          cur_item = pending_items[0];
          pending_items.delete(0);
          in_valid <= 1'b1;
          in_operation <= cur_item.op;
          in_date_key <= cur_item.rec.date_key;
          in_open_price <= cur_item.rec.open_price;
          in_high_price <= cur_item.rec.high_price;
          in_low_price <= cur_item.rec.low_price;
          in_close_price <= cur_item.rec.close_price;
          in_volume <= cur_item.rec.volume;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result with nothing pending", 64'(out_entries_held), '0);
        end else begin
          want = expected_results[0];
          expected_results.delete(0);
          if (out_average_close !== want.average_close)
            report_mismatch("average_close", 64'(out_average_close),
                            64'(want.average_close));
          if (out_entries_held !== want.entries_held)
            report_mismatch("entries_held", 64'(out_entries_held),
                            64'(want.entries_held));
          if (out_found !== want.found)
            report_mismatch("found", 64'(out_found), 64'(want.found));
          if (out_found_open !== want.found_open)
            report_mismatch("found_open", 64'(out_found_open), 64'(want.found_open));
          if (out_found_high !== want.found_high)
            report_mismatch("found_high", 64'(out_found_high), 64'(want.found_high));
          if (out_found_low !== want.found_low)
            report_mismatch("found_low", 64'(out_found_low), 64'(want.found_low));
          if (out_found_close !== want.found_close)
            report_mismatch("found_close", 64'(out_found_close), 64'(want.found_close));
          if (out_found_volume !== want.found_volume)
            report_mismatch("found_volume", 64'(out_found_volume),
                            64'(want.found_volume));
        end
        result_count <= result_count + 1;
      end
      out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == RUN_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    int p;
    int n;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: reset window size, extremes, duplicates and eviction order
    @(negedge clk);
    idle_mode = IDLE_NONE;
    enqueue_directed(OP_LOOKUP, '0, '0, '0, '0, '0, '0, 1'b0);
    enqueue_directed(OP_ADD, '0, '0, '0, '0, '0, '0, 1'b0);
    enqueue_directed(OP_ADD, KEY_ALL_ONES, '1, '1, '1, '1, '1, 1'b0);
    enqueue_directed(OP_LOOKUP, KEY_ALL_ONES, '0, '0, '0, '0, '0, 1'b0);
    enqueue_directed(OP_LOOKUP, '0, '0, '0, '0, '0, '0, 1'b0);
    enqueue_directed(OP_LOOKUP, 27'h5555555, '0, '0, '0, '0, '0, 1'b0);
    enqueue_directed(OP_ADD, 20240105, 32'hAAAAAAAA, 32'h55555555, 32'h12345678,
                     32'h000186A0, 40'hAAAAAAAAAA, 1'b0);
    enqueue_directed(OP_ADD, 20240105, 32'h55555555, 32'hAAAAAAAA, 32'h0,
                     32'hFFFF0000, 40'h5555555555, 1'b0);
    enqueue_directed(OP_LOOKUP, 20240105, '0, '0, '0, '0, '0, 1'b1);
    enqueue_directed(OP_ADD, 20240106, 32'd1, 32'd2, 32'd3, 32'h7FFFFFFF, 40'd4, 1'b0);
    enqueue_directed(OP_ADD, 20240107, 32'd5, 32'd6, 32'd7, 32'd8, 40'd9, 1'b0);
    enqueue_directed(OP_LOOKUP, '0, '0, '0, '0, '0, '0, 1'b0);
    enqueue_directed(OP_ADD, 20240108, 32'd10, 32'd11, 32'd12, 32'd13, 40'd14, 1'b0);
    enqueue_directed(OP_ADD, 20240109, 32'd15, 32'd16, 32'd17, 32'd18, 40'd19, 1'b0);
    // older duplicate gone, newer one must still be found
    enqueue_directed(OP_LOOKUP, 20240105, '0, '0, '0, '0, '0, 1'b0);
    enqueue_directed(OP_ADD, 20240110, 32'd20, 32'd21, 32'd22, 32'd23, 40'd24, 1'b0);
    enqueue_directed(OP_LOOKUP, 20240105, '0, '0, '0, '0, '0, 1'b0);
    enqueue_directed(OP_ADD, 27'h2AAAAAA, '1, '1, '1, '1, '0, 1'b0);
    enqueue_directed(OP_ADD, 27'h2AAAAAA, 32'h0F0F0F0F, '1, '0, '1, 40'hF0F0F0F0F0, 1'b0);
    enqueue_directed(OP_LOOKUP, 27'h2AAAAAA, '0, '0, '0, '0, '0, 1'b0);
    enqueue_directed(OP_LOOKUP, KEY_ALL_ONES, '0, '0, '0, '0, '0, 1'b0);
    wait_drained();

    for (p = 0; p < PHASES; p++) begin
      // window write also empties the window
      @(posedge clk);
      cfg_valid <= 1'b1;
      cfg_window_size <= window_plan[p];
      do @(posedge clk); while (!cfg_ready);
      cfg_valid <= 1'b0;
      window_reg = window_plan[p];
      oldest = '0;
      held = '0;
      close_sum = '0;
      recent_keys.delete();

      @(negedge clk);
      idle_mode = idle_mode_t'(p % 4);
      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        pending_items.insert(pending_items.size(), random_item());
        total_queued++;
      end
      wait_drained();
    end

    repeat (60) @(posedge clk);
    if (expected_results.size() != 0)
      report_mismatch("results never arrived", 64'(expected_results.size()), '0);
    if (fail_count == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

[sim.f]
+incdir+src
src/swa_pkg.sv
src/swa_div.sv
src/swa_ctrl.sv
src/swa_dp.sv
src/sliding_window_average_keyed_lookup.sv
bench/sliding_window_average_keyed_lookup_tb.sv
